// File: rtl/rsc_pkg.sv
// Shared constants, codes and types of the RPN stack calculator.
package rsc_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int WORD_W      = 32;

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_PEEK = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DIV0  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_A,
    S_POP_B,
    S_EXEC,
    S_DIV,
    S_DIV_END,
    S_FIN
  } state_t;

endpackage

// File: rtl/rpn_stack_calculator_core.sv
// Top level of the RPN stack calculator: sequencer, divider and stack RAM.
//
// Commands enter on the in_ channel: in_tuser carries the command code and
// in_tdata the 32-bit value for a push. One result item leaves on the out_
// channel per command: out_tdata carries the result value and the depth after
// the command, out_tuser the status code.
// The stack lives in a RAM with registered read data; the sequencer pops the
// operands one read at a time, computes, and writes the result back on top.
// Push and unknown commands go straight to the result step; peek reads the top
// and writes it back; add, subtract, multiply and divide pop two operands.
// The radix-2 divider makes one quotient bit per cycle for a divide; a new
// command is taken only once the previous one is done.
// Reset empties the stack at once; stack words are not cleared, and a word's
// contents are used only after it has been written.
// A result waits in the output register while the receiver stalls; the next
// command is still accepted and worked, and it holds in its last step until
// the output register is free.
module rpn_stack_calculator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] operand_value, [39:32] zero
  input  logic [2:0]  in_tuser,   // [2:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] result_value, [39:32] depth_after
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int DW = rsc_pkg::DEPTH_W;
  localparam int AW = rsc_pkg::ADDR_W;
  localparam int WW = rsc_pkg::WORD_W;

  rsc_pkg::state_t state_r, state_nxt;
  rsc_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [DW-1:0]   depth_r, depth_nxt;
  logic            hit_r, hit_nxt;
  logic [WW-1:0]   a_r, a_nxt;
  logic [WW-1:0]   b_r, b_nxt;
  logic [WW-1:0]   res_r, res_nxt;
  logic [WW-1:0]   rem_r, rem_nxt;
  logic [WW-1:0]   quo_r, quo_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic            neg_r, neg_nxt;
  logic            empty_r, empty_nxt;
  logic            full_r, full_nxt;
  logic            div0_r, div0_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [WW-1:0]   out_res_r, out_res_nxt;
  logic [1:0]      out_st_r, out_st_nxt;
  logic [7:0]      out_depth_r, out_depth_nxt;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [WW-1:0]   mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [WW-1:0]   mem_rdata;

  logic            in_fire;
  logic            out_free;
  logic [WW-1:0]   a_val;
  logic [WW-1:0]   b_val;
  logic [WW:0]     div_rs;
  logic [WW:0]     div_diff;
  logic            div_ge;
  logic [DW+7:0]   depth_ext;
  rsc_pkg::status_t st_fin;

  rsc_ram #(
    .WIDTH(WW),
    .DEPTH(rsc_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign in_tready = (state_r == rsc_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign a_val    = hit_r ? mem_rdata : '0;
  assign b_val    = hit_r ? mem_rdata : '0;
  assign div_rs   = {rem_r, quo_r[WW-1]};
  assign div_diff = div_rs - {1'b0, a_r};
  assign div_ge   = (div_rs >= {1'b0, a_r});
  assign depth_ext = {8'b0, depth_r};

  always_comb begin
    priority if (div0_r) begin
      st_fin = rsc_pkg::ST_DIV0;
    end else if (empty_r) begin
      st_fin = rsc_pkg::ST_EMPTY;
    end else if (full_r) begin
      st_fin = rsc_pkg::ST_FULL;
    end else begin
      st_fin = rsc_pkg::ST_OK;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    depth_nxt     = depth_r;
    hit_nxt       = hit_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    empty_nxt     = empty_r;
    full_nxt      = full_r;
    div0_nxt      = div0_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    out_st_nxt    = out_st_r;
    out_depth_nxt = out_depth_r;
    mem_we        = 1'b0;
    mem_waddr     = depth_r[AW-1:0];
    mem_wdata     = res_r;
    mem_raddr     = AW'(depth_r - DW'(1));

    unique case (state_r)
      rsc_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = rsc_pkg::cmd_t'(in_tuser);
          res_nxt   = '0;
          empty_nxt = 1'b0;
          full_nxt  = 1'b0;
          div0_nxt  = 1'b0;
          hit_nxt   = (depth_r != '0);
          unique case (rsc_pkg::cmd_t'(in_tuser))
            rsc_pkg::CMD_PUSH: begin
              if (depth_r < DW'(rsc_pkg::STACK_DEPTH)) begin
                mem_we    = 1'b1;
                mem_wdata = in_tdata[WW-1:0];
                depth_nxt = depth_r + DW'(1);
              end else begin
                full_nxt = 1'b1;
              end
              state_nxt = rsc_pkg::S_FIN;
            end
            rsc_pkg::CMD_ADD, rsc_pkg::CMD_SUB, rsc_pkg::CMD_MUL,
            rsc_pkg::CMD_DIV, rsc_pkg::CMD_PEEK: begin
              if (depth_r != '0) begin
                depth_nxt = depth_r - DW'(1);
              end else begin
                empty_nxt = 1'b1;
              end
              state_nxt = rsc_pkg::S_POP_A;
            end
            default: begin
              state_nxt = rsc_pkg::S_FIN;
            end
          endcase
        end
      end

      rsc_pkg::S_POP_A: begin
        a_nxt = a_val;
        if (cmd_r == rsc_pkg::CMD_PEEK) begin
          mem_we    = 1'b1;
          mem_wdata = a_val;
          res_nxt   = a_val;
          depth_nxt = depth_r + DW'(1);
          state_nxt = rsc_pkg::S_FIN;
        end else begin
          hit_nxt = (depth_r != '0);
          if (depth_r != '0) begin
            depth_nxt = depth_r - DW'(1);
          end else begin
            empty_nxt = 1'b1;
          end
          state_nxt = rsc_pkg::S_POP_B;
        end
      end

      rsc_pkg::S_POP_B: begin
        b_nxt     = b_val;
        state_nxt = rsc_pkg::S_EXEC;
      end

      rsc_pkg::S_EXEC: begin
        unique case (cmd_r)
          rsc_pkg::CMD_ADD: res_nxt = b_r + a_r;
          rsc_pkg::CMD_SUB: res_nxt = b_r - a_r;
          rsc_pkg::CMD_MUL: res_nxt = WW'(b_r * a_r);
          default:          res_nxt = '0;
        endcase
        if (cmd_r == rsc_pkg::CMD_DIV) begin
          if (a_r == '0) begin
            div0_nxt  = 1'b1;
            state_nxt = rsc_pkg::S_FIN;
          end else begin
            a_nxt     = a_r[WW-1] ? (WW'(0) - a_r) : a_r;
            quo_nxt   = b_r[WW-1] ? (WW'(0) - b_r) : b_r;
            rem_nxt   = '0;
            cnt_nxt   = '0;
            neg_nxt   = a_r[WW-1] ^ b_r[WW-1];
            state_nxt = rsc_pkg::S_DIV;
          end
        end else begin
          mem_we = 1'b1;
          unique case (cmd_r)
            rsc_pkg::CMD_ADD: mem_wdata = b_r + a_r;
            rsc_pkg::CMD_SUB: mem_wdata = b_r - a_r;
            default:          mem_wdata = WW'(b_r * a_r);
          endcase
          depth_nxt = depth_r + DW'(1);
          state_nxt = rsc_pkg::S_FIN;
        end
      end

      rsc_pkg::S_DIV: begin
        rem_nxt = div_ge ? div_diff[WW-1:0] : div_rs[WW-1:0];
        quo_nxt = {quo_r[WW-2:0], div_ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = rsc_pkg::S_DIV_END;
        end
      end

      rsc_pkg::S_DIV_END: begin
        res_nxt   = neg_r ? (WW'(0) - quo_r) : quo_r;
        mem_we    = 1'b1;
        mem_wdata = neg_r ? (WW'(0) - quo_r) : quo_r;
        depth_nxt = depth_r + DW'(1);
        state_nxt = rsc_pkg::S_FIN;
      end

      rsc_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_st_nxt    = st_fin;
          out_depth_nxt = depth_ext[7:0];
          state_nxt     = rsc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = rsc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsc_pkg::S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    hit_r       <= hit_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    res_r       <= res_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    neg_r       <= neg_nxt;
    empty_r     <= empty_nxt;
    full_r      <= full_nxt;
    div0_r      <= div0_nxt;
    out_res_r   <= out_res_nxt;
    out_st_r    <= out_st_nxt;
    out_depth_r <= out_depth_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_depth_r, out_res_r};
  assign out_tuser  = out_st_r;

endmodule

// File: rtl/rsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
